// ===== hdl/ncac_pkg.sv =====
`default_nettype none

package ncac_pkg;

  localparam logic [7:0] ChDollar = 8'h24;
  localparam logic [7:0] ChStar   = 8'h2A;
  localparam logic [7:0] ChComma  = 8'h2C;
  localparam logic [7:0] ChThree  = 8'h33;

  localparam logic [3:0] HeaderLen = 4'd7;
  localparam logic [3:0] CmdLen    = 4'd3;
  localparam logic [3:0] OffMax    = 4'd15;
  localparam logic [1:0] FieldMax  = 2'd3;
  localparam logic [1:0] FieldHdr  = 2'd0;
  localparam logic [1:0] FieldCmd  = 2'd1;
  localparam logic [1:0] FieldFlag = 2'd2;

  typedef enum logic [2:0] {
    StOk       = 3'd0,
    StBadSum   = 3'd1,
    StNotAck   = 3'd2,
    StWrongCmd = 3'd3,
    StBadFlag  = 3'd4
  } status_e;

  // Field parser state as seen after the current byte, before any end-of-sentence clear.
  typedef struct packed {
    logic [1:0] field_number;
    logic       header_match;
    logic       command_match;
    logic [7:0] third_first_byte;
  } fld_t;

  // Uppercase ASCII hex digit of a nibble.
  function automatic logic [7:0] hex_digit(input logic [3:0] nib);
    logic [7:0] ext;
    ext = {4'h0, nib};
    if (nib < 4'd10) begin
      hex_digit = 8'h30 + ext;
    end else begin
      hex_digit = 8'h37 + ext;
    end
  endfunction

  // Characters of the acknowledgement sentence identifier.
  function automatic logic [7:0] header_char(input logic [2:0] idx);
    case (idx)
      3'd0:    header_char = 8'h50;
      3'd1:    header_char = 8'h4D;
      3'd2:    header_char = 8'h54;
      3'd3:    header_char = 8'h4B;
      3'd4:    header_char = 8'h30;
      3'd5:    header_char = 8'h30;
      3'd6:    header_char = 8'h31;
      default: header_char = 8'h00;
    endcase
  endfunction

endpackage

`default_nettype wire

// ===== hdl/ncac_field_parser.sv =====
`default_nettype none

module ncac_field_parser
  import ncac_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        take_i,
  input  wire logic        clear_i,
  input  wire logic [7:0]  byte_i,
  input  wire logic [23:0] expected_command_i,
  output fld_t             fld_o
);

  logic [1:0] num_q, num_d;
  logic [3:0] off_q, off_d;
  logic       hdr_q, hdr_d;
  logic       cmd_q, cmd_d;
  logic [7:0] third_q, third_d;
  logic       delim;
  logic [7:0] want;

  assign delim = (byte_i == ChComma) || (byte_i == ChStar);

  always_comb begin
    case (off_q[1:0])
      2'd0:    want = expected_command_i[23:16];
      2'd1:    want = expected_command_i[15:8];
      default: want = expected_command_i[7:0];
    endcase
  end

  always_comb begin
    num_d   = num_q;
    off_d   = off_q;
    hdr_d   = hdr_q;
    cmd_d   = cmd_q;
    third_d = third_q;
    if (take_i) begin
      if (delim) begin
        // A delimiter closes the field; the first two must have exact lengths.
        if ((num_q == FieldHdr) && (off_q != HeaderLen)) begin
          hdr_d = 1'b0;
        end
        if ((num_q == FieldCmd) && (off_q != CmdLen)) begin
          cmd_d = 1'b0;
        end
        if (num_q < FieldMax) begin
          num_d = num_q + 2'd1;
        end
        off_d = 4'd0;
      end else begin
        if (num_q == FieldHdr) begin
          if ((off_q >= HeaderLen) || (byte_i != header_char(off_q[2:0]))) begin
            hdr_d = 1'b0;
          end
        end else if (num_q == FieldCmd) begin
          if ((off_q >= CmdLen) || (byte_i != want)) begin
            cmd_d = 1'b0;
          end
        end else if ((num_q == FieldFlag) && (off_q == 4'd0)) begin
          third_d = byte_i;
        end
        if (off_q < OffMax) begin
          off_d = off_q + 4'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_q   <= 2'd0;
      off_q   <= 4'd0;
      hdr_q   <= 1'b1;
      cmd_q   <= 1'b1;
      third_q <= 8'h00;
    end else if (clear_i) begin
      num_q   <= 2'd0;
      off_q   <= 4'd0;
      hdr_q   <= 1'b1;
      cmd_q   <= 1'b1;
      third_q <= 8'h00;
    end else begin
      num_q   <= num_d;
      off_q   <= off_d;
      hdr_q   <= hdr_d;
      cmd_q   <= cmd_d;
      third_q <= third_d;
    end
  end

  assign fld_o.field_number     = num_d;
  assign fld_o.header_match     = hdr_d;
  assign fld_o.command_match    = cmd_d;
  assign fld_o.third_first_byte = third_d;

endmodule

`default_nettype wire

// ===== hdl/nmea_command_ack_checker.sv =====
// Channel   Direction  Payload
// s_axis    in         tdata[7:0] rx_byte, tlast end_of_sentence
// m_axis    out        tdata[0] success, [3:1] status, [11:4] flag_char, [15:12] zero
// cfg_wr    in         cfg_wr_data_i[23:0] expected_command, no handshake
//
// One byte per cycle sustained while m_axis is not stalled. A byte is registered on
// transfer; parser and checksum logic then update the sentence state and, on the last
// byte, load the result register, so the result passes the input and result registers.
// The input register keeps taking bytes while a result waits, until it fills.
// Reset clears all sentence state and sets expected_command to zero.
`default_nettype none

module nmea_command_ack_checker
  import ncac_pkg::*;
#(
  parameter int MAX_LEN = 128
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  input  wire logic        s_axis_tlast,   // end_of_sentence
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata,   // [0] success, [3:1] status, [11:4] flag_char
  input  wire logic        cfg_wr_en_i,
  input  wire logic [23:0] cfg_wr_data_i
);

  localparam int CntW = $clog2(MAX_LEN + 1);
  localparam logic [CntW-1:0] CntMax = CntW'(MAX_LEN);

  logic [23:0]     expected_command_q;
  logic            in_v_q;
  logic [7:0]      in_byte_q;
  logic            in_last_q;
  logic            adv;
  logic            take;
  logic            body;
  logic            clear;

  logic [CntW-1:0] count_q, count_d;
  logic            start_q, start_d;
  logic [7:0]      xor_q, xor_d;
  logic            star_q, star_d;
  logic [7:0]      xas_q, xas_d;
  logic [1:0]      after_q, after_d;
  logic [15:0]     hex_q, hex_d;
  fld_t            fld;

  logic            sum_ok;
  status_e         status;
  logic            out_v_q;
  logic            success_q;
  status_e         status_q;
  logic [7:0]      flag_q;

  assign adv           = in_v_q && (!out_v_q || m_axis_tready);
  assign s_axis_tready = !in_v_q || adv;
  assign take          = adv && (count_q < CntMax);
  assign body          = take && (count_q != '0);
  assign clear         = adv && in_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_command_q <= 24'h000000;
    end else if (cfg_wr_en_i) begin
      expected_command_q <= cfg_wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_v_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
  end

  always_comb begin
    count_d = count_q;
    start_d = start_q;
    xor_d   = xor_q;
    star_d  = star_q;
    xas_d   = xas_q;
    after_d = after_q;
    hex_d   = hex_q;
    if (take) begin
      count_d = count_q + 1'b1;
      if (count_q == '0) begin
        start_d = (in_byte_q == ChDollar);
      end
    end
    if (body) begin
      // Every star restarts the hex pair capture, so the last star decides.
      if (in_byte_q == ChStar) begin
        star_d  = 1'b1;
        xas_d   = xor_q;
        after_d = 2'd0;
        hex_d   = 16'h0000;
      end else if (star_q && (after_q < 2'd2)) begin
        hex_d   = {hex_q[7:0], in_byte_q};
        after_d = after_q + 2'd1;
      end
      xor_d = xor_q ^ in_byte_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      start_q <= 1'b0;
      xor_q   <= 8'h00;
      star_q  <= 1'b0;
      xas_q   <= 8'h00;
      after_q <= 2'd0;
      hex_q   <= 16'h0000;
    end else if (clear) begin
      count_q <= '0;
      start_q <= 1'b0;
      xor_q   <= 8'h00;
      star_q  <= 1'b0;
      xas_q   <= 8'h00;
      after_q <= 2'd0;
      hex_q   <= 16'h0000;
    end else begin
      count_q <= count_d;
      start_q <= start_d;
      xor_q   <= xor_d;
      star_q  <= star_d;
      xas_q   <= xas_d;
      after_q <= after_d;
      hex_q   <= hex_d;
    end
  end

  ncac_field_parser u_fields (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .take_i             (body),
    .clear_i            (clear),
    .byte_i             (in_byte_q),
    .expected_command_i (expected_command_q),
    .fld_o              (fld)
  );

  assign sum_ok = start_d && star_d && (after_d == 2'd2) &&
                  (hex_d == {hex_digit(xas_d[7:4]), hex_digit(xas_d[3:0])});

  always_comb begin
    if (!sum_ok) begin
      status = StBadSum;
    end else if (!(fld.header_match && (fld.field_number >= 2'd1))) begin
      status = StNotAck;
    end else if (!(fld.command_match && (fld.field_number >= 2'd2))) begin
      status = StWrongCmd;
    end else if (fld.third_first_byte != ChThree) begin
      status = StBadFlag;
    end else begin
      status = StOk;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (clear) begin
      out_v_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (clear) begin
      success_q <= (status == StOk);
      status_q  <= status;
      flag_q    <= fld.third_first_byte;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {4'h0, flag_q, status_q, success_q};

endmodule

`default_nettype wire
